/* rtl/sccb_pkg.sv */
// Shared types and constants for the SCCB three-phase write master.
`default_nettype none
package sccb_pkg;

	// Width of the three-byte frame: each byte followed by a don't-care bit.
	localparam int unsigned BASE_FRAME_W = 27;

	// Item kinds on the input channel.
	localparam logic REQ_TICK  = 1'b0;
	localparam logic REQ_WRITE = 1'b1;

	typedef enum logic [3:0] {
		PH_IDLE  = 4'b0001,
		PH_START = 4'b0010,
		PH_DATA  = 4'b0100,
		PH_STOP  = 4'b1000
	} phase_t;

endpackage
`default_nettype wire

/* rtl/sccb_three_phase_write_master.sv */
// Top level: tick-driven SCCB three-phase write master.
//
// Each input transaction is either a timer tick (req_type = 0) or a write
// request (req_type = 1) carrying device address, register address and data.
// A request taken while idle latches the frame {dev,0,reg,0,data,0} at the top
// of a FRAME_BITS-long shift register and enters the start phase; a request
// taken while busy is answered with rejected = 1 and changes nothing. Every
// tick while busy moves the bus lines one step: start takes two ticks (sda
// low, scl low), each frame bit four ticks (set sda, scl high, hold, scl
// low), stop three ticks (sda low, scl high, sda high), after which done_res
// is 1 for that one transaction and the block is idle again. Every input
// transaction yields exactly one output transaction. Throughput is one
// transaction per clock cycle while out_ready is high: the phase, quarter and
// bit counters and the frame shift register update at the accepting edge, and
// the result is held in the output register until taken; in_ready is high
// whenever that register is empty or is being drained in the same cycle. scl
// and sda are the line levels after the transaction and idle high from reset.
`default_nettype none
module sccb_three_phase_write_master #(
	parameter int unsigned FRAME_BITS = 27
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_ready,
	input  wire logic       req_type,
	input  wire logic [7:0] device_addr,
	input  wire logic [7:0] reg_addr,
	input  wire logic [7:0] write_data,
	output logic            out_valid,
	input  wire logic       out_ready,
	output logic            scl,
	output logic            sda,
	output logic            busy_res,
	output logic            done_res,
	output logic            rejected
);

	localparam int unsigned BCW = $clog2(FRAME_BITS);

	// bus state
	sccb_pkg::phase_t      phase_q, phase_d;
	logic [1:0]            quarter_q, quarter_d;
	logic [BCW-1:0]        bit_cnt_q, bit_cnt_d;
	logic [FRAME_BITS-1:0] frame_q, frame_d;
	logic                  clk_lvl_q, clk_lvl_d;
	logic                  dat_lvl_q, dat_lvl_d;

	// result flags and output handshake
	logic                  out_valid_q;
	logic                  done_q, done_d;
	logic                  rej_q, rej_d;

	logic [sccb_pkg::BASE_FRAME_W-1:0] base_frame;
	logic [FRAME_BITS-1:0]             new_frame;
	logic                              accept;

	assign accept   = in_valid && in_ready;
	assign in_ready = !out_valid_q || out_ready;

	assign base_frame = {device_addr, 1'b0, reg_addr, 1'b0, write_data, 1'b0};

	// Align the 27-bit frame to the top of the shift register: pad with zeros
	// when longer, drop the lowest bits when shorter.
	generate
		if (FRAME_BITS >= sccb_pkg::BASE_FRAME_W) begin : g_pad
			if (FRAME_BITS == sccb_pkg::BASE_FRAME_W) begin : g_eq
				assign new_frame = base_frame;
			end else begin : g_gt
				assign new_frame = {base_frame,
					{(FRAME_BITS - sccb_pkg::BASE_FRAME_W){1'b0}}};
			end
		end else begin : g_cut
			assign new_frame = base_frame[sccb_pkg::BASE_FRAME_W-1 -: FRAME_BITS];
		end
	endgenerate

	always_comb begin
		phase_d   = phase_q;
		quarter_d = quarter_q;
		bit_cnt_d = bit_cnt_q;
		frame_d   = frame_q;
		clk_lvl_d = clk_lvl_q;
		dat_lvl_d = dat_lvl_q;
		done_d    = 1'b0;
		rej_d     = 1'b0;
		if (req_type == sccb_pkg::REQ_WRITE) begin
			if (phase_q != sccb_pkg::PH_IDLE) begin
				rej_d = 1'b1;
			end else begin
				frame_d   = new_frame;
				phase_d   = sccb_pkg::PH_START;
				quarter_d = 2'd0;
				bit_cnt_d = '0;
			end
		end else begin
			case (phase_q)
				sccb_pkg::PH_START: begin
					if (quarter_q == 2'd0) begin
						dat_lvl_d = 1'b0;
						quarter_d = 2'd1;
					end else begin
						clk_lvl_d = 1'b0;
						quarter_d = 2'd0;
						bit_cnt_d = '0;
						phase_d   = sccb_pkg::PH_DATA;
					end
				end
				sccb_pkg::PH_DATA: begin
					case (quarter_q)
						2'd0: begin
							dat_lvl_d = frame_q[FRAME_BITS-1];
							quarter_d = 2'd1;
						end
						2'd1: begin
							clk_lvl_d = 1'b1;
							quarter_d = 2'd2;
						end
						2'd2: begin
							quarter_d = 2'd3;
						end
						default: begin
							clk_lvl_d = 1'b0;
							quarter_d = 2'd0;
							frame_d   = {frame_q[FRAME_BITS-2:0], 1'b0};
							if (bit_cnt_q == BCW'(FRAME_BITS - 1)) begin
								bit_cnt_d = '0;
								phase_d   = sccb_pkg::PH_STOP;
							end else begin
								bit_cnt_d = bit_cnt_q + 1'b1;
							end
						end
					endcase
				end
				sccb_pkg::PH_STOP: begin
					if (quarter_q == 2'd0) begin
						dat_lvl_d = 1'b0;
						quarter_d = 2'd1;
					end else if (quarter_q == 2'd1) begin
						clk_lvl_d = 1'b1;
						quarter_d = 2'd2;
					end else begin
						dat_lvl_d = 1'b1;
						quarter_d = 2'd0;
						phase_d   = sccb_pkg::PH_IDLE;
						done_d    = 1'b1;
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= sccb_pkg::PH_IDLE;
			quarter_q   <= 2'd0;
			bit_cnt_q   <= '0;
			frame_q     <= '0;
			clk_lvl_q   <= 1'b1;
			dat_lvl_q   <= 1'b1;
			out_valid_q <= 1'b0;
			done_q      <= 1'b0;
			rej_q       <= 1'b0;
		end else begin
			if (accept) begin
				phase_q   <= phase_d;
				quarter_q <= quarter_d;
				bit_cnt_q <= bit_cnt_d;
				frame_q   <= frame_d;
				clk_lvl_q <= clk_lvl_d;
				dat_lvl_q <= dat_lvl_d;
				done_q    <= done_d;
				rej_q     <= rej_d;
			end
			if (accept) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Bus state only moves when a new result is loaded, so the held result
	// reads straight from it.
	assign out_valid = out_valid_q;
	assign scl       = clk_lvl_q;
	assign sda       = dat_lvl_q;
	assign busy_res  = (phase_q != sccb_pkg::PH_IDLE);
	assign done_res  = done_q;
	assign rejected  = rej_q;

endmodule
`default_nettype wire

/* rtl/sccb_chk.sv */
// Port-level assertion checker for the SCCB write master, with its bind.
`default_nettype none
module sccb_chk (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       in_valid,
	input wire logic       in_ready,
	input wire logic       req_type,
	input wire logic [7:0] device_addr,
	input wire logic [7:0] reg_addr,
	input wire logic [7:0] write_data,
	input wire logic       out_valid,
	input wire logic       out_ready,
	input wire logic       scl,
	input wire logic       sda,
	input wire logic       busy_res,
	input wire logic       done_res,
	input wire logic       rejected
);

	// stop completes with both lines released and the bus free
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && done_res |-> !busy_res && scl && sda)
		else $error("done without idle bus");

	// a rejection only happens during a transaction
	a_rej_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && rejected |-> busy_res && !done_res)
		else $error("rejected while idle");

	// only a write request can be rejected
	a_rej_req: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && req_type == sccb_pkg::REQ_TICK |=> !rejected)
		else $error("tick rejected");

	// input side never stalls while the output register is empty
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("stall with empty output");

	// stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(scl) && $stable(sda)
			&& $stable(busy_res) && $stable(done_res) && $stable(rejected))
		else $error("result changed under stall");

endmodule

bind sccb_three_phase_write_master sccb_chk u_sccb_chk (.*);
`default_nettype wire

/* sim/sccb_write_checker.sv */
`timescale 1ns / 100ps
// Checker for the SCCB write master: watches both channels, predicts line levels, compares.
module sccb_write_checker #(
	parameter int unsigned FRAME_BITS = 27
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	input  logic       in_ready,
	input  logic       req_type,
	input  logic [7:0] device_addr,
	input  logic [7:0] reg_addr,
	input  logic [7:0] write_data,
	input  logic       out_valid,
	input  logic       out_ready,
	input  logic       scl,
	input  logic       sda,
	input  logic       busy_res,
	input  logic       done_res,
	input  logic       rejected,
	output int         mismatches,
	output int         awaiting
);

	localparam int unsigned CNT_W = $clog2(FRAME_BITS + 1);

	typedef struct packed {
		logic scl;
		logic sda;
		logic busy;
		logic done;
		logic rej;
	} bus_levels_t;

	bus_levels_t levels_q[$];

	// shadow of the master's bus state
	sccb_pkg::phase_t      phase;
	logic [1:0]            quarter;
	logic [CNT_W-1:0]      bit_idx;
	logic [FRAME_BITS-1:0] frame;
	logic                  scl_lvl;
	logic                  sda_lvl;

	always @(posedge clk or negedge arst_n) begin : track
		logic [63:0] wide;
		bus_levels_t want;
		bus_levels_t got;
		logic        done_now;
		logic        rej_now;
		if (!arst_n) begin
			phase = sccb_pkg::PH_IDLE;
			quarter = '0;
			bit_idx = '0;
			frame = '0;
			scl_lvl = 1'b1;
			sda_lvl = 1'b1;
			levels_q.delete();
			mismatches = 0;
			awaiting <= 0;
		end else begin
			// drain first: a result taken at this edge belongs to an older transaction
			if (out_valid && out_ready) begin
				got = '{scl, sda, busy_res, done_res, rejected};
				if (levels_q.size() == 0) begin
					$display("%0t: result with none expected: %s scl=%b sda=%b busy=%b done=%b rej=%b",
						$time, "actual", got.scl, got.sda, got.busy, got.done, got.rej);
					mismatches++;
				end else begin
					want = levels_q.pop_front();
					if (got !== want) begin
						$display("%0t: mismatch: expected scl=%b sda=%b busy=%b done=%b rej=%b,",
							$time, want.scl, want.sda, want.busy, want.done, want.rej);
						$display("%0t:           actual scl=%b sda=%b busy=%b done=%b rej=%b",
							$time, got.scl, got.sda, got.busy, got.done, got.rej);
						mismatches++;
					end
				end
			end
			if (in_valid && in_ready) begin
				done_now = 1'b0;
				rej_now = 1'b0;
				if (req_type == sccb_pkg::REQ_WRITE) begin
					if (phase != sccb_pkg::PH_IDLE) begin
						rej_now = 1'b1;
					end else begin
						wide = {37'd0, device_addr, 1'b0, reg_addr, 1'b0, write_data, 1'b0};
						if (FRAME_BITS >= sccb_pkg::BASE_FRAME_W)
							wide = wide << (FRAME_BITS - sccb_pkg::BASE_FRAME_W);
						else
							wide = wide >> (sccb_pkg::BASE_FRAME_W - FRAME_BITS);
						frame = wide[FRAME_BITS-1:0];
						phase = sccb_pkg::PH_START;
						quarter = '0;
						bit_idx = '0;
					end
				end else begin
					case (phase)
					sccb_pkg::PH_START: begin
						if (quarter == 2'd0) begin
							sda_lvl = 1'b0;
							quarter = 2'd1;
						end else begin
							scl_lvl = 1'b0;
							quarter = 2'd0;
							bit_idx = '0;
							phase = sccb_pkg::PH_DATA;
						end
					end
					sccb_pkg::PH_DATA: begin
						case (quarter)
						2'd0: begin
							sda_lvl = frame[FRAME_BITS - 1 - bit_idx];
							quarter = 2'd1;
						end
						2'd1: begin
							scl_lvl = 1'b1;
							quarter = 2'd2;
						end
						2'd2: quarter = 2'd3;
						default: begin
							scl_lvl = 1'b0;
							quarter = 2'd0;
							bit_idx = bit_idx + 1'b1;
							if (bit_idx >= FRAME_BITS) begin
								bit_idx = '0;
								phase = sccb_pkg::PH_STOP;
							end
						end
						endcase
					end
					sccb_pkg::PH_STOP: begin
						if (quarter == 2'd0) begin
							sda_lvl = 1'b0;
							quarter = 2'd1;
						end else if (quarter == 2'd1) begin
							scl_lvl = 1'b1;
							quarter = 2'd2;
						end else begin
							sda_lvl = 1'b1;
							quarter = 2'd0;
							phase = sccb_pkg::PH_IDLE;
							done_now = 1'b1;
						end
					end
					default: ;
					endcase
				end
				levels_q.push_back('{scl_lvl, sda_lvl, phase != sccb_pkg::PH_IDLE,
					done_now, rej_now});
			end
			awaiting <= levels_q.size();
		end
	end

endmodule

/* sim/sccb_three_phase_write_master_tb.sv */
`timescale 1ns / 100ps
// Testbench top for the SCCB write master: stimulus, back-pressure and verdict.
module sccb_three_phase_write_master_tb;

	localparam int unsigned FRAME_BITS  = 27;
	// ticks for one whole write: start, every frame bit, stop
	localparam int unsigned FRAME_TICKS = 2 + 4 * FRAME_BITS + 3;
	// directed part plus the random part
	localparam int unsigned TOTAL_ITEMS = 1325;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       req_type = sccb_pkg::REQ_TICK;
	logic [7:0] device_addr = '0;
	logic [7:0] reg_addr = '0;
	logic [7:0] write_data = '0;
	logic       out_ready = 1'b0;

	wire logic  in_ready;
	wire logic  out_valid;
	wire logic  scl;
	wire logic  sda;
	wire logic  busy_res;
	wire logic  done_res;
	wire logic  rejected;

	int mismatches;
	int awaiting;
	int items_sent = 0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	sccb_three_phase_write_master #(
		.FRAME_BITS(FRAME_BITS)
	) dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.req_type   (req_type),
		.device_addr(device_addr),
		.reg_addr   (reg_addr),
		.write_data (write_data),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.scl        (scl),
		.sda        (sda),
		.busy_res   (busy_res),
		.done_res   (done_res),
		.rejected   (rejected)
	);

	sccb_write_checker #(
		.FRAME_BITS(FRAME_BITS)
	) u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.req_type   (req_type),
		.device_addr(device_addr),
		.reg_addr   (reg_addr),
		.write_data (write_data),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.scl        (scl),
		.sda        (sda),
		.busy_res   (busy_res),
		.done_res   (done_res),
		.rejected   (rejected),
		.mismatches (mismatches),
		.awaiting   (awaiting)
	);

	// Byte values lean toward the extremes so all-ones and all-zeros frames show up often.
	function automatic logic [7:0] pick_byte();
		case ($urandom_range(0, 5))
		0: return 8'h00;
		1: return 8'hFF;
		default: return 8'($urandom);
		endcase
	endfunction

	// Offer one input transaction and hold it until accepted.
	// Gaps are inserted before the item, one nonblocking write of in_valid per falling edge,
	// so valid is never dropped and raised again in the same time step.
	// Items 700..899 go out back to back with no gaps.
	task automatic send_item(input logic kind, input logic [7:0] dev, input logic [7:0] sub,
			input logic [7:0] dat);
		@(negedge clk);
		while (!(items_sent >= 700 && items_sent < 900) && $urandom_range(99) < 11) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid    <= 1'b1;
		req_type    <= kind;
		device_addr <= dev;
		reg_addr    <= sub;
		write_data  <= dat;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		items_sent++;
	endtask

	// Ticks carry random byte fields, which the block must ignore.
	task automatic send_tick();
		send_item(sccb_pkg::REQ_TICK, 8'($urandom), 8'($urandom), 8'($urandom));
	endtask

	task automatic send_write(input logic [7:0] dev, input logic [7:0] sub,
			input logic [7:0] dat);
		send_item(sccb_pkg::REQ_WRITE, dev, sub, dat);
	endtask

	// Result side: random stalls about 11% of cycles, one long hold-off early on so the
	// output register fills and in_ready drops, then a stretch that always accepts.
	initial begin : sink
		int cyc;
		int hold;
		cyc = 0;
		hold = 0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			cyc++;
			if (cyc == 400)
				hold = 100;
			if (hold > 0) begin
				hold--;
				out_ready <= 1'b0;
			end else if (cyc >= 800 && cyc < 1100) begin
				out_ready <= 1'b1;
			end else begin
				out_ready <= ($urandom_range(99) >= 11);
			end
		end
	end

	initial begin : stimulus
		int ticks;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed: tick while idle (lines stay high), a write with extreme bytes,
		// a request while busy (rejected, lines hold), the start condition and the
		// first few frame bits, then another request in the middle of the data phase.
		send_tick();
		send_write(8'hFF, 8'h00, 8'hFF);
		send_write(8'h00, 8'hFF, 8'h00);
		repeat (18) send_tick();
		send_write(8'hFF, 8'hFF, 8'hFF);
		send_tick();

		// Random: mostly complete writes with random bytes, separated by idle ticks.
		// About one write in ten is cut short, so the next request lands while busy;
		// a few stray requests are also dropped into the middle of frames.
		while (items_sent < TOTAL_ITEMS) begin
			repeat ($urandom_range(0, 3)) send_tick();
			send_write(pick_byte(), pick_byte(), pick_byte());
			if ($urandom_range(9) == 0)
				ticks = $urandom_range(1, FRAME_TICKS);
			else
				ticks = FRAME_TICKS + $urandom_range(0, 2);
			repeat (ticks) begin
				if ($urandom_range(99) < 3)
					send_write(pick_byte(), pick_byte(), pick_byte());
				send_tick();
			end
		end

		@(negedge clk);
		in_valid <= 1'b0;

		// wait for every predicted result to be taken, then let any stray results arrive
		while (awaiting != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);

		if (mismatches == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

	// watchdog: far beyond the slowest legal run
	initial begin : watchdog
		#2000000;
		$display("FAIL");
		$finish;
	end

endmodule
